// ----- rtl/dro_pkg.sv -----
// Shared types, constants and calendar tables for the date range overlap block.
`timescale 1ns / 1ps

package dro_pkg;

    localparam int MAX_YEAR   = 9999;
    localparam int NUM_STAGES = 5;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;
    localparam int ORD_W   = 23;
    localparam int QUO_W   = 8;
    localparam int MOFF_W  = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam int          PROD_W       = YEAR_W + 13;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [DAY_W-1:0]   first_start_day;
        logic [MONTH_W-1:0] first_start_month;
        logic [YEAR_W-1:0]  first_start_year;
        logic [DAY_W-1:0]   first_end_day;
        logic [MONTH_W-1:0] first_end_month;
        logic [YEAR_W-1:0]  first_end_year;
        logic [DAY_W-1:0]   second_start_day;
        logic [MONTH_W-1:0] second_start_month;
        logic [YEAR_W-1:0]  second_start_year;
        logic [DAY_W-1:0]   second_end_day;
        logic [MONTH_W-1:0] second_end_month;
        logic [YEAR_W-1:0]  second_end_year;
    } t_in;

    typedef struct packed {
        logic [COUNT_W-1:0] overlap_days;
        logic               date_error;
    } t_out;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } t_pipe_ctl;

    // Days in a month of a common year; zero for codes that are no month.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days of a common year that come before the first of the month.
    function automatic logic [MOFF_W-1:0] month_base(input logic [MONTH_W-1:0] m);
        logic [MOFF_W-1:0] base;
        unique case (m)
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base;
    endfunction

endpackage

// ----- rtl/dro_pipe_ctl.sv -----
// Valid bits and per-stage load enables of the five-stage pipeline.
`timescale 1ns / 1ps

module dro_pipe_ctl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    output dro_pkg::t_pipe_ctl  o_ctl
);

    logic [dro_pkg::NUM_STAGES-1:0] r_v;
    logic [dro_pkg::NUM_STAGES-1:0] n_v;
    logic [dro_pkg::NUM_STAGES-1:0] w_ready;

    always_comb begin
        w_ready[dro_pkg::NUM_STAGES-1] = !r_v[dro_pkg::NUM_STAGES-1] || !i_stall;
        for (int k = dro_pkg::NUM_STAGES - 2; k >= 0; k--) begin
            w_ready[k] = !r_v[k] || w_ready[k+1];
        end
    end

    always_comb begin
        n_v = r_v;
        if (w_ready[0]) begin
            n_v[0] = i_valid;
        end
        for (int k = 1; k < dro_pkg::NUM_STAGES; k++) begin
            if (w_ready[k]) begin
                n_v[k] = r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_ctl.load = w_ready;
    assign o_stall    = !w_ready[0];
    assign o_valid    = r_v[dro_pkg::NUM_STAGES-1];

endmodule

// ----- rtl/dro_date_ord.sv -----
// Three-stage conversion of one calendar date to a day ordinal with a validity flag.
`timescale 1ns / 1ps

module dro_date_ord (
    input  logic                         i_clk,
    input  dro_pkg::t_pipe_ctl           i_ctl,
    input  logic [dro_pkg::DAY_W-1:0]    i_day,
    input  logic [dro_pkg::MONTH_W-1:0]  i_month,
    input  logic [dro_pkg::YEAR_W-1:0]   i_year,
    output logic [dro_pkg::ORD_W-1:0]    o_ord,
    output logic                         o_date_ok
);

    // stage 1: year minus one and quotients by one hundred
    logic [dro_pkg::PROD_W-1:0]  w_prod_y;
    logic [dro_pkg::PROD_W-1:0]  w_prod_p;
    logic [dro_pkg::YEAR_W-1:0]  n1_p;

    logic [dro_pkg::DAY_W-1:0]   r1_day;
    logic [dro_pkg::MONTH_W-1:0] r1_month;
    logic [dro_pkg::YEAR_W-1:0]  r1_year;
    logic [dro_pkg::YEAR_W-1:0]  r1_p;
    logic [dro_pkg::QUO_W-1:0]   r1_qy;
    logic [dro_pkg::QUO_W-1:0]   r1_qp;
    logic                        r1_year_ok;

    assign n1_p     = i_year - dro_pkg::YEAR_W'(1);
    assign w_prod_y = dro_pkg::PROD_W'(i_year) * dro_pkg::PROD_W'(dro_pkg::DIV100_MUL);
    assign w_prod_p = dro_pkg::PROD_W'(n1_p) * dro_pkg::PROD_W'(dro_pkg::DIV100_MUL);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r1_day     <= i_day;
            r1_month   <= i_month;
            r1_year    <= i_year;
            r1_p       <= n1_p;
            r1_qy      <= w_prod_y[dro_pkg::DIV100_SHIFT +: dro_pkg::QUO_W];
            r1_qp      <= w_prod_p[dro_pkg::DIV100_SHIFT +: dro_pkg::QUO_W];
            r1_year_ok <= (i_year != '0) && (32'(i_year) <= 32'(dro_pkg::MAX_YEAR));
        end
    end

    // stage 2: leap rule, range checks, ordinal of the year start, month offset
    logic [dro_pkg::YEAR_W-1:0]  w_rem_y;
    logic                        w_leap;
    logic [dro_pkg::DAY_W-1:0]   w_dim;
    logic                        w_month_ok;
    logic [dro_pkg::ORD_W-1:0]   n2_base;
    logic [dro_pkg::MOFF_W-1:0]  n2_moff;

    logic [dro_pkg::ORD_W-1:0]   r2_base;
    logic [dro_pkg::MOFF_W-1:0]  r2_moff;
    logic [dro_pkg::DAY_W-1:0]   r2_day;
    logic                        r2_ok;

    assign w_rem_y    = r1_year - dro_pkg::YEAR_W'(r1_qy) * dro_pkg::YEAR_W'(100);
    assign w_leap     = (r1_year[1:0] == 2'b00) && ((w_rem_y != '0) || (r1_qy[1:0] == 2'b00));
    assign w_month_ok = (r1_month >= dro_pkg::MONTH_JAN) && (r1_month <= dro_pkg::MONTH_DEC);

    always_comb begin
        w_dim = dro_pkg::month_len(r1_month);
        if (r1_month == dro_pkg::MONTH_FEB && w_leap) begin
            w_dim = 5'd29;
        end
    end

    assign n2_base = dro_pkg::ORD_W'(r1_p) * dro_pkg::ORD_W'(365)
                   + dro_pkg::ORD_W'(r1_p >> 2)
                   - dro_pkg::ORD_W'(r1_qp)
                   + dro_pkg::ORD_W'(r1_qp >> 2);
    assign n2_moff = dro_pkg::month_base(r1_month)
                   + dro_pkg::MOFF_W'(w_leap && (r1_month > dro_pkg::MONTH_FEB));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r2_base <= n2_base;
            r2_moff <= n2_moff;
            r2_day  <= r1_day;
            r2_ok   <= r1_year_ok && w_month_ok && (r1_day != '0) && (r1_day <= w_dim);
        end
    end

    // stage 3: final ordinal
    logic [dro_pkg::ORD_W-1:0] r3_ord;
    logic                      r3_ok;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r3_ord <= r2_base + dro_pkg::ORD_W'(r2_moff) + dro_pkg::ORD_W'(r2_day);
            r3_ok  <= r2_ok;
        end
    end

    assign o_ord     = r3_ord;
    assign o_date_ok = r3_ok;

endmodule

// ----- rtl/dro_overlap.sv -----
// Two-stage intersection of two ordinal ranges into a saturated day count.
`timescale 1ns / 1ps

module dro_overlap (
    input  logic                      i_clk,
    input  dro_pkg::t_pipe_ctl        i_ctl,
    input  logic [dro_pkg::ORD_W-1:0] i_ord_s1,
    input  logic [dro_pkg::ORD_W-1:0] i_ord_e1,
    input  logic [dro_pkg::ORD_W-1:0] i_ord_s2,
    input  logic [dro_pkg::ORD_W-1:0] i_ord_e2,
    input  logic [3:0]                i_date_ok,
    output dro_pkg::t_out             o_data
);

    logic [dro_pkg::ORD_W-1:0] r4_lo;
    logic [dro_pkg::ORD_W-1:0] r4_hi;
    logic                      r4_bad;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r4_lo  <= (i_ord_s1 > i_ord_s2) ? i_ord_s1 : i_ord_s2;
            r4_hi  <= (i_ord_e1 < i_ord_e2) ? i_ord_e1 : i_ord_e2;
            r4_bad <= (i_date_ok != 4'hF);
        end
    end

    logic [dro_pkg::ORD_W:0] w_span;
    dro_pkg::t_out           n5_out;
    dro_pkg::t_out           r5_out;

    assign w_span = {1'b0, r4_hi} - {1'b0, r4_lo} + (dro_pkg::ORD_W + 1)'(1);

    always_comb begin
        n5_out.date_error   = r4_bad;
        n5_out.overlap_days = '0;
        if (!r4_bad && (r4_hi >= r4_lo)) begin
            if (w_span > (dro_pkg::ORD_W + 1)'(dro_pkg::COUNT_MAX)) begin
                n5_out.overlap_days = dro_pkg::COUNT_MAX;
            end else begin
                n5_out.overlap_days = w_span[dro_pkg::COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r5_out <= n5_out;
        end
    end

    assign o_data = r5_out;

endmodule

// ----- rtl/date_range_overlap_days.sv -----
// An accepted input beat passes through the registers of stages one to five, in order, to its result beat.
// Throughput: one beat per cycle while o_stall is low; the five stages each hold one beat.
// A result waits in the last stage while stalled; earlier stages keep filling.
// Input stall rises only when all five stages are full and the output is stalled.
// Reset (synchronous, active low) clears all valid bits; no beat in flight survives it.
`timescale 1ns / 1ps

module date_range_overlap_days (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  dro_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output dro_pkg::t_out o_data
);

    dro_pkg::t_pipe_ctl        w_ctl;
    logic [dro_pkg::ORD_W-1:0] w_ord_s1;
    logic [dro_pkg::ORD_W-1:0] w_ord_e1;
    logic [dro_pkg::ORD_W-1:0] w_ord_s2;
    logic [dro_pkg::ORD_W-1:0] w_ord_e2;
    logic [3:0]                w_date_ok;

    dro_pipe_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_ctl   (w_ctl)
    );

    dro_date_ord u_ord_s1 (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_day     (i_data.first_start_day),
        .i_month   (i_data.first_start_month),
        .i_year    (i_data.first_start_year),
        .o_ord     (w_ord_s1),
        .o_date_ok (w_date_ok[0])
    );

    dro_date_ord u_ord_e1 (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_day     (i_data.first_end_day),
        .i_month   (i_data.first_end_month),
        .i_year    (i_data.first_end_year),
        .o_ord     (w_ord_e1),
        .o_date_ok (w_date_ok[1])
    );

    dro_date_ord u_ord_s2 (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_day     (i_data.second_start_day),
        .i_month   (i_data.second_start_month),
        .i_year    (i_data.second_start_year),
        .o_ord     (w_ord_s2),
        .o_date_ok (w_date_ok[2])
    );

    dro_date_ord u_ord_e2 (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_day     (i_data.second_end_day),
        .i_month   (i_data.second_end_month),
        .i_year    (i_data.second_end_year),
        .o_ord     (w_ord_e2),
        .o_date_ok (w_date_ok[3])
    );

    dro_overlap u_overlap (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_ord_s1  (w_ord_s1),
        .i_ord_e1  (w_ord_e1),
        .i_ord_s2  (w_ord_s2),
        .i_ord_e2  (w_ord_e2),
        .i_date_ok (w_date_ok),
        .o_data    (o_data)
    );

endmodule

// ----- rtl/dro_chk.sv -----
// Port-level checks of the date range overlap block and their bind.
`timescale 1ns / 1ps

module dro_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input dro_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_stall,
    input dro_pkg::t_out o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result beat changed or dropped");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.date_error |-> o_data.overlap_days == '0)
        else $error("error beat carries a nonzero count");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat after reset");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");

endmodule

bind date_range_overlap_days dro_chk u_dro_chk (.*);
